[src/msa_pkg.sv]
// Package with shared types and constants of the multichannel sample averager.
`timescale 1ns / 1ps
package msa_pkg;

  localparam int NUM_CH     = 6;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 32;
  localparam int COUNT_W    = 15;
  localparam int QUOT_W     = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // Control from the sequencer to the accumulator and divider lanes.
  typedef struct packed {
    logic clear;
    logic add;
    logic div_start;
  } lane_ctrl_t;

  typedef struct packed {
    logic restart;
    sample_t [NUM_CH-1:0] samples;
  } frame_t;

  typedef struct packed {
    sample_t [NUM_CH-1:0] avgs;
    count_t frames_summed;
    logic averages_fresh;
    logic count_overflow;
  } result_t;

endpackage

[src/msa_if.sv]
// Valid/ready channel interface carrying one item payload.
`timescale 1ns / 1ps
interface msa_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/msa_lane.sv]
// One channel lane: running sum and a restoring divider for its average.
`timescale 1ns / 1ps
module msa_lane
  import msa_pkg::*;
#(
  parameter bit USED = 1'b1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample,
  input  count_t     divisor,
  output logic       busy,
  output sample_t    avg
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  sum_t                sum_r, sum_nxt;
  logic [SUM_W-1:0]    quot_r;
  logic [COUNT_W:0]    rem_r;
  logic                neg_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  sample_t             avg_r;

  logic [COUNT_W+1:0]  trial;
  logic [SUM_W-1:0]    quot_fix;

  // Sum update with optional clear ahead of the add.
  always_comb begin
    sum_nxt = ctrl.clear ? '0 : sum_r;
    if (ctrl.add && USED) begin
      sum_nxt = sum_nxt + SUM_W'(sample);
    end
  end

  // One quotient bit per cycle on the magnitude of the sum.
  assign trial    = {rem_r, quot_r[SUM_W-1]} - {2'b00, divisor};
  assign quot_fix = neg_r ? (~quot_r + 1'b1) : quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      busy_r <= 1'b0;
      step_r <= '0;
      avg_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      if (ctrl.div_start && USED) begin
        busy_r <= 1'b1;
        step_r <= '0;
        neg_r  <= sum_r[SUM_W-1];
        quot_r <= sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(SUM_W)) begin
          busy_r <= 1'b0;
          avg_r  <= quot_fix[QUOT_W-1:0];
        end else begin
          step_r <= step_r + 1'b1;
          if (!trial[COUNT_W+1]) begin
            rem_r  <= trial[COUNT_W:0];
            quot_r <= {quot_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r  <= {rem_r[COUNT_W-1:0], quot_r[SUM_W-1]};
            quot_r <= {quot_r[SUM_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign busy = busy_r;
  assign avg  = avg_r;

endmodule

[src/multichannel_sample_averager.sv]
// Top level of the multichannel sample averager: sequencer, six lanes and result merge.
`timescale 1ns / 1ps
// Each accepted frame updates six 32-bit channel sums in the add state. When the
// frame count exceeds ready_threshold, six lane dividers run in parallel, one
// quotient bit per cycle, before the frame's result is registered; otherwise the
// result is registered without a division. The 32-step restoring divider in each
// lane thus sets how long a frame takes when averages are recomputed. One frame
// is in work at a time; the next frame is taken as soon as the result register
// is free or being drained.
module multichannel_sample_averager
  import msa_pkg::*;
#(
  parameter int AUX_CHANNELS = 4,
  parameter int MAX_FRAMES   = 32767
) (
  input  logic          clk,
  input  logic          rst_n,
  msa_if.sink           in_ch,
  msa_if.source         out_ch,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [COUNT_W-1:0] cfg_ready_threshold
);

  typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_DIV, ST_OUT} state_t;

  state_t     state_r;
  count_t     thresh_r, count_r;
  logic       fresh_r, ovf_r, out_valid_r;
  logic       started_r;
  result_t    out_r;
  lane_ctrl_t ctrl;
  logic [NUM_CH-1:0] lane_busy;
  sample_t [NUM_CH-1:0] lane_avg;
  frame_t     frame_r;
  count_t     count_base;

  assign cfg_ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);

  // Count as seen after any restart clearing.
  assign count_base = frame_r.restart ? '0 : count_r;

  // Lane control: in the add state clear on restart and add unless saturated; start one division per fresh frame.
  always_comb begin
    ctrl = '0;
    if (state_r == ST_ADD) begin
      ctrl.clear = frame_r.restart;
      ctrl.add   = (count_base != COUNT_W'(MAX_FRAMES));
    end
    ctrl.div_start = (state_r == ST_DIV) && fresh_r && !started_r;
  end

  // Lanes, one per channel; unused auxiliary lanes keep zero.
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    msa_lane #(.USED(g < 2 + AUX_CHANNELS)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .sample  (frame_r.samples[g]),
      .divisor (count_r),
      .busy    (lane_busy[g]),
      .avg     (lane_avg[g])
    );
  end

  // Sequencer and merged result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thresh_r    <= COUNT_W'(100);
      count_r     <= '0;
      out_valid_r <= 1'b0;
      fresh_r     <= 1'b0;
      ovf_r       <= 1'b0;
      started_r   <= 1'b0;
      out_r.averages_fresh <= 1'b0;
    end else begin
      if (cfg_valid) thresh_r <= cfg_ready_threshold;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            frame_r <= in_ch.data;
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          started_r <= 1'b0;
          if (count_base == COUNT_W'(MAX_FRAMES)) begin
            count_r <= count_base;
            ovf_r   <= 1'b1;
            fresh_r <= 1'b0;
          end else begin
            count_r <= count_base + 1'b1;
            ovf_r   <= 1'b0;
            fresh_r <= (count_base + 1'b1) > thresh_r;
          end
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (ctrl.div_start) started_r <= 1'b1;
          if (!fresh_r || (started_r && !(|lane_busy))) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r) begin
            out_r.avgs           <= lane_avg;
            out_r.frames_summed  <= count_r;
            out_r.averages_fresh <= fresh_r;
            out_r.count_overflow <= ovf_r;
            out_valid_r          <= 1'b1;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTH
  // A saturated frame never reports fresh averages.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_r.averages_fresh && out_r.count_overflow))
    else $error("fresh and overflow together");
  // Lanes only divide while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_busy) |-> (state_r == ST_DIV))
    else $error("divider busy outside divide state");
  // The count never exceeds its saturation value.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_FRAMES))
    else $error("count beyond limit");
`endif

endmodule

[tb/msa_checker.sv]
// Checker that predicts the averager's result items and compares them with the block's output.
`timescale 1ns / 1ps
module msa_checker
  import msa_pkg::*;
#(
  parameter int AUX_CHANNELS = 4,
  parameter int MAX_FRAMES   = 32767
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_ready,
  input  frame_t  in_data,
  input  logic    out_valid,
  input  logic    out_ready,
  input  result_t out_data,
  input  logic    cfg_valid,
  input  logic    cfg_ready,
  input  count_t  cfg_threshold,
  output int      fail_count,
  output int      pending_results
);

  sum_t    run_sums [NUM_CH];
  sample_t avg_hold [NUM_CH];
  count_t  frame_cnt;
  count_t  threshold;
  result_t expected_q [$];

  assign pending_results = expected_q.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Advance the averaging state by one frame and return the result it yields.
  function automatic result_t average_frame(input frame_t f);
    result_t r;
    logic signed [32:0] q;
    r = '0;
    if (f.restart) begin
      foreach (run_sums[c]) run_sums[c] = '0;
      frame_cnt = '0;
    end
    if (frame_cnt >= count_t'(MAX_FRAMES)) begin
      r.count_overflow = 1'b1;
    end else begin
      for (int c = 0; c < NUM_CH; c++)
        if (c < 2 + AUX_CHANNELS) run_sums[c] = run_sums[c] + sum_t'(f.samples[c]);
      frame_cnt = frame_cnt + 1'b1;
      if (frame_cnt > threshold) begin
        r.averages_fresh = 1'b1;
        for (int c = 0; c < NUM_CH; c++)
          if (c < 2 + AUX_CHANNELS) begin
            q = $signed(run_sums[c]) / $signed({18'd0, frame_cnt});
            avg_hold[c] = q[15:0];
          end
      end
    end
    for (int c = 0; c < NUM_CH; c++) r.avgs[c] = avg_hold[c];
    r.frames_summed = frame_cnt;
    return r;
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (run_sums[c]) begin
        run_sums[c] = '0;
        avg_hold[c] = '0;
      end
      frame_cnt = '0;
      threshold = count_t'(100);
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_threshold;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = expected_q.pop_front();
          for (int c = 0; c < NUM_CH; c++)
            if (out_data.avgs[c] !== want.avgs[c])
              report_mismatch($sformatf("average ch%0d", c), out_data.avgs[c], want.avgs[c]);
          if (out_data.frames_summed !== want.frames_summed)
            report_mismatch("frames_summed", out_data.frames_summed, want.frames_summed);
          if (out_data.averages_fresh !== want.averages_fresh)
            report_mismatch("averages_fresh", out_data.averages_fresh, want.averages_fresh);
          if (out_data.count_overflow !== want.count_overflow)
            report_mismatch("count_overflow", out_data.count_overflow, want.count_overflow);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(average_frame(in_data));
    end
  end

endmodule

[tb/testbench.sv]
// Top of the averager testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import msa_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  count_t cfg_threshold = '0;
  int     fail_count;
  int     pending_results;
  int     cycle_cnt = 0;
  int     send_idle_pct = 0;
  int     sink_stall_pct = 0;

  msa_if #(.payload_t(frame_t))  in_ch ();
  msa_if #(.payload_t(result_t)) out_ch ();

  multichannel_sample_averager i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ch               (in_ch),
    .out_ch              (out_ch),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_ready_threshold (cfg_threshold)
  );

  msa_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_threshold   (cfg_threshold),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[multichannel_sample_averager] ERROR");
      $finish;
    end
  end

  // The result side stalls at random at the current rate.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Sample values: mostly random, sometimes the extremes.
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return sample_t'(16'sh7FFF);
      1: return sample_t'(16'sh8000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Send one frame, idling first at random and holding valid until taken.
  // Valid is left to the next send or to drain, so it is assigned once per edge.
  task automatic send_frame(input logic restart, input logic use_random);
    frame_t f;
    f.restart = restart;
    for (int c = 0; c < NUM_CH; c++) f.samples[c] = use_random ? pick_sample() : '0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.data <= f;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fixed(input logic restart, input sample_t v);
    frame_t f;
    f.restart = restart;
    for (int c = 0; c < NUM_CH; c++) f.samples[c] = v;
    in_ch.data <= f;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, wait for all results, then let the divider settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_threshold(input count_t v);
    drain();
    cfg_threshold <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, restarts and thresholds of zero, one and 32767.
    sink_stall_pct = 0;
    send_fixed(1'b0, sample_t'(16'sh7FFF));
    send_fixed(1'b0, sample_t'(16'sh8000));
    write_threshold(count_t'(0));
    send_fixed(1'b1, sample_t'(16'sh8000));
    send_fixed(1'b0, sample_t'(16'sh8000));
    send_fixed(1'b0, sample_t'(16'sh7FFF));
    send_fixed(1'b0, sample_t'(-16'sd3));
    send_fixed(1'b1, sample_t'(16'sh7FFF));
    send_fixed(1'b0, sample_t'(16'sd1));
    send_fixed(1'b1, sample_t'(16'sd5555));
    write_threshold(count_t'(1));
    send_fixed(1'b1, sample_t'(-16'sd7));
    send_fixed(1'b0, sample_t'(16'sd2));
    send_fixed(1'b0, sample_t'(16'sh5555));
    write_threshold(count_t'(32767));
    send_fixed(1'b1, sample_t'(16'sd100));
    send_fixed(1'b0, sample_t'(16'sd100));

    // Threshold at its high end, then a restart.
    write_threshold(count_t'(32766));
    send_fixed(1'b1, sample_t'(16'sh7FFF));
    send_fixed(1'b0, sample_t'(16'sh8000));
    send_fixed(1'b1, sample_t'(16'sh8000));

    // Random phases with different idling, stalling and thresholds.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 64; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin send_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      write_threshold(phase < 4 ? count_t'($urandom_range(20)) : count_t'($urandom_range(2)));
      n = 0;
      while (n < 112) begin
        send_frame($urandom_range(19) == 0, 1'b1);
        n++;
      end
    end
    write_threshold(count_t'(100));

    drain();
    if (fail_count == 0) begin
      $display("[multichannel_sample_averager] OK");
    end else begin
      $display("[multichannel_sample_averager] ERROR");
    end
    $finish;
  end

endmodule
